FILE: sv/cdq_pkg.sv
// Package: shared types, codes and constants for the circular deque.
`timescale 1ns / 1ps
package cdq_pkg;

    localparam int VAL_W         = 32;
    localparam int KIND_W        = 3;
    localparam int CAP_W         = 5;
    localparam int CAP_RESET     = 16;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic signed [VAL_W-1:0] EMPTY_VALUE = -VAL_W'(1);

    typedef enum logic [KIND_W-1:0] {
        KIND_INS_FRONT = 3'd0,
        KIND_INS_REAR  = 3'd1,
        KIND_DEL_FRONT = 3'd2,
        KIND_DEL_REAR  = 3'd3,
        KIND_PEEK      = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                    ok;
        logic signed [VAL_W-1:0] front_value;
        logic signed [VAL_W-1:0] rear_value;
        logic                    is_empty;
        logic                    is_full;
    } res_t;

endpackage

FILE: sv/cdq_store.sv
// Ring store: one write port and two registered read ports.
`timescale 1ns / 1ps
module cdq_store #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [IDX_W-1:0]                 waddr,
    input  logic signed [cdq_pkg::VAL_W-1:0] wdata,
    input  logic                             re,
    input  logic [IDX_W-1:0]                 raddr_front,
    input  logic [IDX_W-1:0]                 raddr_rear,
    output logic signed [cdq_pkg::VAL_W-1:0] rdata_front,
    output logic signed [cdq_pkg::VAL_W-1:0] rdata_rear
);
    import cdq_pkg::*;

    logic signed [VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_front <= mem[raddr_front];
            rdata_rear  <= mem[raddr_rear];
        end
    end

endmodule

FILE: sv/cdq_ctrl.sv
// Control: capacity register, ring pointers, operation decode and result assembly.
`timescale 1ns / 1ps
module cdq_ctrl #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  cdq_pkg::req_t                    req,
    output logic                             done,
    output cdq_pkg::res_t                    result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cdq_pkg::CAP_W-1:0]        cfg_data,
    output logic                             mem_we,
    output logic [IDX_W-1:0]                 mem_waddr,
    output logic signed [cdq_pkg::VAL_W-1:0] mem_wdata,
    output logic                             mem_re,
    output logic [IDX_W-1:0]                 mem_raddr_front,
    output logic [IDX_W-1:0]                 mem_raddr_rear,
    input  logic signed [cdq_pkg::VAL_W-1:0] mem_rdata_front,
    input  logic signed [cdq_pkg::VAL_W-1:0] mem_rdata_rear
);
    import cdq_pkg::*;

    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_INIT  = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic              empty_reg, empty_next;
    logic              ok_reg, ok_next;

    logic              accept;
    logic              cfg_write;
    logic              full_now;
    logic [CNT_W-1:0]  tail_plus;
    logic [CNT_W-1:0]  head_plus;
    logic [IDX_W-1:0]  tail_inc;
    logic [IDX_W-1:0]  head_inc;
    logic [IDX_W-1:0]  tail_dec;
    logic [IDX_W-1:0]  head_dec;
    logic [CNT_W-1:0]  cap_eff;

    // wrapped neighbors of the current pointers
    assign tail_plus = CNT_W'(tail_reg) + CNT_W'(1);
    assign head_plus = CNT_W'(head_reg) + CNT_W'(1);
    assign tail_inc  = (tail_plus >= cap_reg) ? '0 : IDX_W'(tail_plus);
    assign head_inc  = (head_plus >= cap_reg) ? '0 : IDX_W'(head_plus);
    assign tail_dec  = (tail_reg == '0) ? IDX_W'(cap_reg - CNT_W'(1)) : tail_reg - IDX_W'(1);
    assign head_dec  = (head_reg == '0) ? IDX_W'(cap_reg - CNT_W'(1)) : head_reg - IDX_W'(1);
    assign full_now  = !empty_reg && (tail_inc == head_reg);

    // clamp the requested capacity into 1..DEPTH
    always_comb
    begin
        priority if (cfg_data == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (32'(cfg_data) > DEPTH)
        begin
            cap_eff = CNT_W'(DEPTH);
        end
        else
        begin
            cap_eff = CNT_W'(cfg_data);
        end
    end

    assign busy      = (state_reg == ST_READ);
    assign accept    = start && !busy;
    assign cfg_ready = (state_reg == ST_IDLE) && !start;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg   <= CNT_W'(CAP_INIT);
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg   <= cap_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
            ok_reg    <= ok_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cap_next   = cap_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        ok_next    = ok_reg;
        mem_we     = 1'b0;
        mem_waddr  = head_reg;
        mem_wdata  = req.value;

        unique case (state_reg)
            ST_IDLE, ST_RESP:
            begin
                state_next = accept ? ST_READ : ST_IDLE;
            end
            ST_READ:
            begin
                state_next = ST_RESP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            // a capacity change empties the deque
            cap_next   = cap_eff;
            head_next  = '0;
            tail_next  = '0;
            empty_next = 1'b1;
        end
        else if (accept)
        begin
            ok_next = 1'b0;
            unique case (req.kind)
                KIND_INS_FRONT, KIND_INS_REAR:
                begin
                    if (!full_now)
                    begin
                        ok_next = 1'b1;
                        mem_we  = 1'b1;
                        if (empty_reg)
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b0;
                            mem_waddr  = '0;
                        end
                        else if (req.kind == KIND_INS_FRONT)
                        begin
                            head_next = head_dec;
                            mem_waddr = head_dec;
                        end
                        else
                        begin
                            tail_next = tail_inc;
                            mem_waddr = tail_inc;
                        end
                    end
                end
                KIND_DEL_FRONT, KIND_DEL_REAR:
                begin
                    if (!empty_reg)
                    begin
                        ok_next = 1'b1;
                        if (head_reg == tail_reg)
                        begin
                            // last entry gone: rewind both pointers
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b1;
                        end
                        else if (req.kind == KIND_DEL_FRONT)
                        begin
                            head_next = head_inc;
                        end
                        else
                        begin
                            tail_next = tail_dec;
                        end
                    end
                end
                KIND_PEEK:
                begin
                    ok_next = 1'b1;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    // read both ends once the pointers have settled
    assign mem_re          = (state_reg == ST_READ);
    assign mem_raddr_front = head_reg;
    assign mem_raddr_rear  = tail_reg;

    assign done               = (state_reg == ST_RESP);
    assign result.ok          = ok_reg;
    assign result.front_value = empty_reg ? EMPTY_VALUE : mem_rdata_front;
    assign result.rear_value  = empty_reg ? EMPTY_VALUE : mem_rdata_rear;
    assign result.is_empty    = empty_reg;
    assign result.is_full     = full_now;

endmodule

FILE: sv/circular_deque.sv
// Top level: double-ended queue over a ring store with a configurable capacity.
// Sequence: the accepting edge updates the pointers, then ST_READ registers the store read;
//   done is high in ST_RESP, when the registered store data is valid.
// A new request is taken in the result cycle (ST_RESP) but not during the store read (busy);
//   each pointer update is followed by a store read before the next request is taken.
// Reset: pointers zero, deque empty, capacity 16 (clamped to DEPTH); store contents undefined.
// Results appear for one cycle on done; the receiver cannot stall.
`timescale 1ns / 1ps
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  cdq_pkg::req_t             req,
    output logic                      done,
    output cdq_pkg::res_t             result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [cdq_pkg::CAP_W-1:0] cfg_data
);
    import cdq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic signed [VAL_W-1:0] mem_wdata;
    logic                    mem_re;
    logic [IDX_W-1:0]        mem_raddr_front;
    logic [IDX_W-1:0]        mem_raddr_rear;
    logic signed [VAL_W-1:0] mem_rdata_front;
    logic signed [VAL_W-1:0] mem_rdata_rear;

    cdq_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req             (req),
        .done            (done),
        .result          (result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_re          (mem_re),
        .mem_raddr_front (mem_raddr_front),
        .mem_raddr_rear  (mem_raddr_rear),
        .mem_rdata_front (mem_rdata_front),
        .mem_rdata_rear  (mem_rdata_rear)
    );

    cdq_store #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .clk         (clk),
        .we          (mem_we),
        .waddr       (mem_waddr),
        .wdata       (mem_wdata),
        .re          (mem_re),
        .raddr_front (mem_raddr_front),
        .raddr_rear  (mem_raddr_rear),
        .rdata_front (mem_rdata_front),
        .rdata_rear  (mem_rdata_rear)
    );

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not enter the read cycle");

    a_busy_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("read cycle not followed by a result");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a preceding read cycle");

    a_empty_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.is_empty |-> !result.is_full)
        else $error("deque reported empty and full at once");

endmodule

FILE: sim/testbench.sv
// Testbench for circular_deque: directed and random requests checked against a deque scoreboard.
`timescale 1ns / 1ps
module testbench;
    import cdq_pkg::*;

    class deque_scoreboard;
        logic [VAL_W-1:0] ring [DEPTH_DEFAULT];
        int               head_idx;
        int               tail_idx;
        bit               vacant;
        logic [CAP_W-1:0] cap_reg;
        res_t             expected_status_q [$];
        int               error_count;

        function new();
            foreach (ring[i])
            begin
                ring[i] = '0;
            end
            head_idx    = 0;
            tail_idx    = 0;
            vacant      = 1'b1;
            cap_reg     = CAP_W'(CAP_RESET);
            error_count = 0;
        endfunction

        function int eff_capacity();
            if (cap_reg == 0)
                return 1;
            if (int'(cap_reg) > DEPTH_DEFAULT)
                return DEPTH_DEFAULT;
            return int'(cap_reg);
        endfunction

        function int step_fwd(int i, int c);
            return (i + 1 >= c) ? 0 : i + 1;
        endfunction

        function int step_back(int i, int c);
            return (i == 0 || i >= c) ? c - 1 : i - 1;
        endfunction

        function bit holds_capacity(int c);
            return !vacant && step_fwd(tail_idx, c) == head_idx;
        endfunction

        function int pending();
            return expected_status_q.size();
        endfunction

        // A capacity write also empties the deque.
        function void set_capacity(logic [CAP_W-1:0] c);
            cap_reg  = c;
            head_idx = 0;
            tail_idx = 0;
            vacant   = 1'b1;
        endfunction

        task report_mismatch(string msg);
            error_count++;
            $display("MISMATCH at %0t ns: %s", $time, msg);
        endtask

        task apply_request(req_t r);
            int   c;
            bit   ok;
            res_t want;
            c  = eff_capacity();
            ok = 1'b0;
            case (r.kind)
                KIND_INS_FRONT, KIND_INS_REAR:
                begin
                    if (!holds_capacity(c))
                    begin
                        ok = 1'b1;
                        if (vacant)
                        begin
                            head_idx = 0;
                            tail_idx = 0;
                            vacant   = 1'b0;
                        end
                        else if (r.kind == KIND_INS_FRONT)
                            head_idx = step_back(head_idx, c);
                        else
                            tail_idx = step_fwd(tail_idx, c);
                        ring[(r.kind == KIND_INS_FRONT) ? head_idx : tail_idx] = r.value;
                    end
                end
                KIND_DEL_FRONT, KIND_DEL_REAR:
                begin
                    if (!vacant)
                    begin
                        ok = 1'b1;
                        if (head_idx == tail_idx)
                            set_capacity(cap_reg);
                        else if (r.kind == KIND_DEL_FRONT)
                            head_idx = step_fwd(head_idx, c);
                        else
                            tail_idx = step_back(tail_idx, c);
                    end
                end
                KIND_PEEK:
                    ok = 1'b1;
                default:
                    ok = 1'b0;
            endcase
            want.ok          = ok;
            want.front_value = vacant ? EMPTY_VALUE : ring[head_idx];
            want.rear_value  = vacant ? EMPTY_VALUE : ring[tail_idx];
            want.is_empty    = vacant;
            want.is_full     = holds_capacity(c);
            expected_status_q.push_back(want);
        endtask

        task check_status(res_t got);
            res_t  want;
            string diffs;
            if (expected_status_q.size() == 0)
            begin
                report_mismatch($sformatf("result with no request waiting: %p", got));
                return;
            end
            want  = expected_status_q.pop_front();
            diffs = "";
            if (got.ok !== want.ok)
                diffs = {diffs, $sformatf(" ok %0b/%0b", got.ok, want.ok)};
            if (got.front_value !== want.front_value)
                diffs = {diffs, $sformatf(" front %0d/%0d", got.front_value, want.front_value)};
            if (got.rear_value !== want.rear_value)
                diffs = {diffs, $sformatf(" rear %0d/%0d", got.rear_value, want.rear_value)};
            if (got.is_empty !== want.is_empty)
                diffs = {diffs, $sformatf(" empty %0b/%0b", got.is_empty, want.is_empty)};
            if (got.is_full !== want.is_full)
                diffs = {diffs, $sformatf(" full %0b/%0b", got.is_full, want.is_full)};
            if (diffs != "")
                report_mismatch({"result field(s) got/expected:", diffs});
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    req_t             req;
    logic             done;
    res_t             result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data;

    deque_scoreboard sb;

    circular_deque i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_status(result);
    end

    function automatic req_t make_req(logic [KIND_W-1:0] k, logic [VAL_W-1:0] v);
        req_t r;
        r.kind  = k;
        r.value = v;
        return r;
    endfunction

    // insert_pct steers the deque toward full or toward empty.
    function automatic req_t random_request(int insert_pct);
        int   roll;
        req_t r;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            r.kind = KIND_W'($urandom_range(int'(KIND_PEEK) + 1, 2**KIND_W - 1));
        else if (roll < 12)
            r.kind = KIND_PEEK;
        else if ($urandom_range(0, 99) < insert_pct)
            r.kind = $urandom_range(0, 1) ? KIND_INS_FRONT : KIND_INS_REAR;
        else
            r.kind = $urandom_range(0, 1) ? KIND_DEL_FRONT : KIND_DEL_REAR;
        case ($urandom_range(0, 9))
            0:       r.value = 32'h7FFF_FFFF;
            1:       r.value = 32'h8000_0000;
            2:       r.value = EMPTY_VALUE;
            default: r.value = $urandom;
        endcase
        return r;
    endfunction

    task automatic issue_request(input req_t r);
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        sb.apply_request(r);
        @(negedge clk);
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        wait_drained();
        repeat (3) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        do @(posedge clk); while (!cfg_ready);
        sb.set_capacity(c);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [CAP_W-1:0] cap_plan [12];
        int               idle_pct;
        int               pause_at;
        int               sent;
        int               run_len;
        int               bias;
        int               k;

        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty deque, single entries, unknown kinds, full deque.
        issue_request(make_req(KIND_PEEK, 32'h1234_5678));
        issue_request(make_req(KIND_DEL_FRONT, '0));
        issue_request(make_req(KIND_DEL_REAR, '0));
        issue_request(make_req(KIND_INS_FRONT, 32'h7FFF_FFFF));
        issue_request(make_req(KIND_PEEK, '1));
        issue_request(make_req(KIND_DEL_FRONT, '0));
        issue_request(make_req(KIND_INS_REAR, 32'h8000_0000));
        issue_request(make_req(KIND_DEL_REAR, '0));
        issue_request(make_req(KIND_INS_REAR, '0));
        issue_request(make_req(KIND_INS_FRONT, EMPTY_VALUE));
        issue_request(make_req(KIND_INS_FRONT, 32'h5555_5555));
        for (k = int'(KIND_PEEK) + 1; k < 2**KIND_W; k++)
            issue_request(make_req(KIND_W'(k), 32'hDEAD_BEEF));
        write_capacity(CAP_W'(2));
        issue_request(make_req(KIND_INS_REAR, 32'hAAAA_AAAA));
        issue_request(make_req(KIND_INS_FRONT, 32'd1));
        issue_request(make_req(KIND_INS_REAR, 32'd2));
        issue_request(make_req(KIND_INS_FRONT, 32'd3));
        issue_request(make_req(KIND_DEL_FRONT, '0));
        issue_request(make_req(KIND_DEL_REAR, '0));
        issue_request(make_req(KIND_DEL_REAR, '0));
        write_capacity('0);
        issue_request(make_req(KIND_INS_FRONT, 32'd7));
        issue_request(make_req(KIND_INS_REAR, 32'd8));
        issue_request(make_req(KIND_DEL_FRONT, '0));

        cap_plan = '{CAP_W'(1), CAP_W'(0), CAP_W'(16), CAP_W'(31), CAP_W'(17), CAP_W'(2),
                     CAP_W'(3), CAP_W'(5), '0, '0, '0, '0};
        for (int i = 8; i < 12; i++)
            cap_plan[i] = CAP_W'($urandom_range(0, 31));

        for (int b = 0; b < 12; b++)
        begin
            write_capacity(cap_plan[b]);
            idle_pct = (b % 3 == 0) ? 0 : (b % 3 == 1) ? 76 : 24;
            pause_at = $urandom_range(10, 70);
            sent     = 0;
            while (sent < 85)
            begin
                run_len = $urandom_range(3, 30);
                case ($urandom_range(0, 2))
                    0:       bias = 85;
                    1:       bias = 15;
                    default: bias = 50;
                endcase
                for (int j = 0; j < run_len && sent < 85; j++)
                begin
                    issue_request(random_request(bias));
                    sent++;
                    if (sent == pause_at)
                        wait_drained();
                    else if ($urandom_range(0, 99) < idle_pct)
                    begin
                        start <= 1'b0;
                        repeat ($urandom_range(1, 5)) @(negedge clk);
                    end
                end
            end
        end

        wait_drained();
        repeat (4) @(negedge clk);
        if (sb.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: filelist.f
sv/cdq_pkg.sv
sv/cdq_store.sv
sv/cdq_ctrl.sv
sv/circular_deque.sv
sim/testbench.sv
